>>> sv/sct_pkg.sv
// ----------------------------------------------------------------------------
// Source character tokenizer package
// Shared token record, queue entry, scanner modes, token kinds and character
// constants used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package sct_pkg;

    // Token kinds
    localparam logic [3:0] KIND_LBRACKET = 4'd0;
    localparam logic [3:0] KIND_RBRACKET = 4'd1;
    localparam logic [3:0] KIND_LBRACE   = 4'd2;
    localparam logic [3:0] KIND_RBRACE   = 4'd3;
    localparam logic [3:0] KIND_LPAREN   = 4'd4;
    localparam logic [3:0] KIND_RPAREN   = 4'd5;
    localparam logic [3:0] KIND_IDENT    = 4'd6;
    localparam logic [3:0] KIND_NUMBER   = 4'd7;
    localparam logic [3:0] KIND_STRING   = 4'd8;
    localparam logic [3:0] KIND_BAD      = 4'd9;
    localparam logic [3:0] KIND_UNTERM   = 4'd10;

    // Characters
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_LESS     = 8'h3C;
    localparam logic [7:0] CH_GREATER  = 8'h3E;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;

    // Counter limits and reset values
    localparam logic [19:0] LINE_MAX = 20'hFFFFF;
    localparam logic [15:0] COL_MAX  = 16'hFFFF;
    localparam logic [23:0] POS_MAX  = 24'hFFFFFF;
    localparam logic [31:0] NUM_MAX  = 32'hFFFFFFFF;
    localparam logic [19:0] LINE_ONE = 20'd1;
    localparam logic [15:0] COL_ONE  = 16'd1;

    // Scanner modes
    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_IDENT  = 5'b00010,
        MODE_NUMBER = 5'b00100,
        MODE_STRING = 5'b01000,
        MODE_DRAIN  = 5'b10000
    } mode_t;

    // One token
    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] col_first;
        logic [15:0] col_after;
        logic [23:0] span_begin;
        logic [23:0] span_end;
        logic [31:0] num_value;
    } tok_t;

    // One or two tokens caused by one byte
    typedef struct packed {
        tok_t        tok0;
        tok_t        tok1;
        logic        two;
        logic [19:0] line_no;
    } entry_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDER);
    endfunction

    function automatic logic is_bracket(input logic [7:0] c);
        return (c == CH_LBRACKET) || (c == CH_RBRACKET) || (c == CH_LBRACE) ||
               (c == CH_RBRACE) || (c == CH_LPAREN) || (c == CH_RPAREN);
    endfunction

    function automatic logic [3:0] bracket_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            CH_LBRACKET: k = KIND_LBRACKET;
            CH_RBRACKET: k = KIND_RBRACKET;
            CH_LBRACE:   k = KIND_LBRACE;
            CH_RBRACE:   k = KIND_RBRACE;
            CH_LPAREN:   k = KIND_LPAREN;
            default:     k = KIND_RPAREN;
        endcase
        return k;
    endfunction

    function automatic logic ends_ident(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_NEWLINE) || (c == CH_TAB) ||
               (c == CH_CR) || (c == CH_COLON) || (c == CH_LESS) ||
               (c == CH_GREATER) || is_bracket(c);
    endfunction

endpackage

>>> sv/source_char_tokenizer.sv
// ----------------------------------------------------------------------------
// Source character tokenizer
// Scans source bytes and emits bracket, identifier, number and string
// tokens with line, column and byte span.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, ch, last) takes one source byte per
//   transfer; last marks the final byte of a source, after which all
//   counters return to their start values for the next source.
//   Output channel (out_valid, out_stall, kind .. run_last) gives one token
//   per transfer; run_last is high on the last token a byte caused.
//   Throughput: one byte per cycle while in_stall is low. A byte that
//   closes an identifier or a number and is itself a token gives two
//   tokens, which leave one after the other; the output port's one token
//   per cycle while out_stall is low sets that pace. A token passes the
//   token queue and then the output register before it is offered.
//   Bytes that cause no token (whitespace, bytes inside a token, bytes
//   dropped after an error) are taken and produce nothing.
//   A stalled receiver holds the current token steady; the token queue of
//   QUEUE_DEPTH entries absorbs further tokens, and in_stall rises only
//   when that queue is full.
//   Reset: asynchronous, active low; queue emptied, scanner at line 1,
//   column 1, offset 0.
// ----------------------------------------------------------------------------
module source_char_tokenizer
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  kind,
    output logic [19:0] line_no,
    output logic [15:0] col_first,
    output logic [15:0] col_after,
    output logic [23:0] span_begin,
    output logic [23:0] span_end,
    output logic [31:0] num_value,
    output logic        run_last
);

    sct_pkg::entry_t wr_data, rd_data;
    logic            push, pop, full, empty;

    // Scan bytes into token entries
    sct_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ch       (ch),
        .last     (last),
        .full     (full),
        .push     (push),
        .wr_data  (wr_data)
    );

    // Buffer entries between the two sides
    sct_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_data),
        .full    (full),
        .pop     (pop),
        .rd_data (rd_data),
        .empty   (empty)
    );

    // Deliver tokens one per transfer
    sct_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .rd_data    (rd_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .line_no    (line_no),
        .col_first  (col_first),
        .col_after  (col_after),
        .span_begin (span_begin),
        .span_end   (span_end),
        .num_value  (num_value),
        .run_last   (run_last)
    );

endmodule

>>> sv/sct_front.sv
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts source bytes, tracks position counters and scanner mode, and
// pushes the one or two tokens that a byte closes into the token queue.
// ----------------------------------------------------------------------------
module sct_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      ch,
    input  logic            last,
    input  logic            full,
    output logic            push,
    output sct_pkg::entry_t wr_data
);

    sct_pkg::mode_t mode_reg, mode_next, fresh_mode;
    logic [19:0] line_reg, line_next, fresh_line;
    logic [15:0] col_reg, col_next, fresh_col, col_inc;
    logic [15:0] tok_col_reg, tok_col_next;
    logic [23:0] pos_reg, pos_next, pos_inc;
    logic [23:0] tok_pos_reg, tok_pos_next;
    logic [31:0] acc_reg, acc_next, fresh_acc, acc_sat;
    logic [35:0] acc_mul;
    logic        accept;
    logic        use_fresh;
    logic        fresh_v, close_v, emit_v;
    sct_pkg::tok_t fresh_tok, close_tok, own_tok, emit_tok;

    assign in_stall = full;
    assign accept   = in_valid & ~full;

    // Saturating counter steps and next number value
    always_comb
    begin
        col_inc = (col_reg == sct_pkg::COL_MAX) ? col_reg : col_reg + 16'd1;
        pos_inc = (pos_reg == sct_pkg::POS_MAX) ? pos_reg : pos_reg + 24'd1;
        acc_mul = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {32'd0, ch[3:0]};
        acc_sat = (acc_mul[35:32] != 4'd0) ? sct_pkg::NUM_MAX : acc_mul[31:0];
    end

    // Classify a byte that starts from the idle mode
    always_comb
    begin
        fresh_tok.kind       = sct_pkg::KIND_BAD;
        fresh_tok.col_first  = col_reg;
        fresh_tok.col_after  = col_inc;
        fresh_tok.span_begin = pos_reg;
        fresh_tok.span_end   = pos_inc;
        fresh_tok.num_value  = '0;
        fresh_v    = 1'b0;
        fresh_mode = sct_pkg::MODE_IDLE;
        fresh_line = line_reg;
        fresh_col  = col_inc;
        fresh_acc  = acc_reg;
        if (sct_pkg::is_bracket(ch))
        begin
            fresh_tok.kind = sct_pkg::bracket_kind(ch);
            fresh_v        = 1'b1;
        end
        else if (ch == sct_pkg::CH_QUOTE)
        begin
            if (last)
            begin
                fresh_tok.kind = sct_pkg::KIND_UNTERM;
                fresh_v        = 1'b1;
            end
            else
            begin
                fresh_mode = sct_pkg::MODE_STRING;
            end
        end
        else if (ch == sct_pkg::CH_SPACE || ch == sct_pkg::CH_TAB || ch == sct_pkg::CH_CR)
        begin
            fresh_v = 1'b0;
        end
        else if (ch == sct_pkg::CH_NEWLINE)
        begin
            fresh_line = (line_reg == sct_pkg::LINE_MAX) ? line_reg : line_reg + 20'd1;
            fresh_col  = sct_pkg::COL_ONE;
        end
        else if (sct_pkg::is_digit(ch))
        begin
            fresh_acc = {28'd0, ch[3:0]};
            if (last)
            begin
                fresh_tok.kind      = sct_pkg::KIND_NUMBER;
                fresh_tok.num_value = {28'd0, ch[3:0]};
                fresh_v             = 1'b1;
            end
            else
            begin
                fresh_mode = sct_pkg::MODE_NUMBER;
            end
        end
        else if (sct_pkg::is_alpha(ch))
        begin
            if (last)
            begin
                fresh_tok.kind = sct_pkg::KIND_IDENT;
                fresh_v        = 1'b1;
            end
            else
            begin
                fresh_mode = sct_pkg::MODE_IDENT;
            end
        end
        else
        begin
            fresh_v    = 1'b1;
            fresh_mode = sct_pkg::MODE_DRAIN;
        end
    end

    // Advance the scanner by one byte
    always_comb
    begin
        mode_next    = mode_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        tok_col_next = tok_col_reg;
        pos_next     = pos_reg;
        tok_pos_next = tok_pos_reg;
        acc_next     = acc_reg;
        use_fresh    = 1'b0;
        close_v      = 1'b0;
        emit_v       = 1'b0;

        close_tok.kind       = sct_pkg::KIND_IDENT;
        close_tok.col_first  = tok_col_reg;
        close_tok.col_after  = col_reg;
        close_tok.span_begin = tok_pos_reg;
        close_tok.span_end   = pos_reg;
        close_tok.num_value  = '0;

        own_tok.kind       = sct_pkg::KIND_IDENT;
        own_tok.col_first  = tok_col_reg;
        own_tok.col_after  = col_inc;
        own_tok.span_begin = tok_pos_reg;
        own_tok.span_end   = pos_inc;
        own_tok.num_value  = '0;

        case (mode_reg)
            sct_pkg::MODE_IDENT:
            begin
                if (!sct_pkg::ends_ident(ch))
                begin
                    col_next = col_inc;
                    pos_next = pos_inc;
                    emit_v   = last;
                end
                else
                begin
                    close_v   = 1'b1;
                    use_fresh = 1'b1;
                end
            end
            sct_pkg::MODE_NUMBER:
            begin
                if (sct_pkg::is_digit(ch))
                begin
                    acc_next          = acc_sat;
                    col_next          = col_inc;
                    pos_next          = pos_inc;
                    own_tok.kind      = sct_pkg::KIND_NUMBER;
                    own_tok.num_value = acc_sat;
                    emit_v            = last;
                end
                else
                begin
                    close_tok.kind      = sct_pkg::KIND_NUMBER;
                    close_tok.num_value = acc_reg;
                    close_v             = 1'b1;
                    use_fresh           = 1'b1;
                end
            end
            sct_pkg::MODE_STRING:
            begin
                col_next = col_inc;
                pos_next = pos_inc;
                if (ch == sct_pkg::CH_QUOTE)
                begin
                    own_tok.kind = sct_pkg::KIND_STRING;
                    emit_v       = 1'b1;
                    mode_next    = sct_pkg::MODE_IDLE;
                end
                else if (last)
                begin
                    own_tok.kind = sct_pkg::KIND_UNTERM;
                    emit_v       = 1'b1;
                end
            end
            sct_pkg::MODE_DRAIN:
            begin
                col_next = col_inc;
                pos_next = pos_inc;
            end
            default:
            begin
                use_fresh = 1'b1;
            end
        endcase

        emit_tok = own_tok;
        if (use_fresh)
        begin
            tok_col_next = col_reg;
            tok_pos_next = pos_reg;
            mode_next    = fresh_mode;
            line_next    = fresh_line;
            col_next     = fresh_col;
            pos_next     = pos_inc;
            acc_next     = fresh_acc;
            emit_v       = fresh_v;
            emit_tok     = fresh_tok;
        end

        // End of source: return to the reset state
        if (last)
        begin
            mode_next    = sct_pkg::MODE_IDLE;
            line_next    = sct_pkg::LINE_ONE;
            col_next     = sct_pkg::COL_ONE;
            tok_col_next = sct_pkg::COL_ONE;
            pos_next     = '0;
            tok_pos_next = '0;
            acc_next     = '0;
        end
    end

    // Build the queue entry
    always_comb
    begin
        wr_data.tok0    = close_v ? close_tok : emit_tok;
        wr_data.tok1    = emit_tok;
        wr_data.two     = close_v & emit_v;
        wr_data.line_no = line_reg;
        push            = accept & (close_v | emit_v);
    end

    // Hold scanner state, advance on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= sct_pkg::MODE_IDLE;
            line_reg    <= sct_pkg::LINE_ONE;
            col_reg     <= sct_pkg::COL_ONE;
            tok_col_reg <= sct_pkg::COL_ONE;
            pos_reg     <= '0;
            tok_pos_reg <= '0;
            acc_reg     <= '0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            tok_col_reg <= tok_col_next;
            pos_reg     <= pos_next;
            tok_pos_reg <= tok_pos_next;
            acc_reg     <= acc_next;
        end
    end

endmodule

>>> sv/sct_queue.sv
// ----------------------------------------------------------------------------
// Token queue
// Short first-in first-out buffer of token entries between the front end
// and the back end.
// ----------------------------------------------------------------------------
module sct_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sct_pkg::entry_t wr_data,
    output logic            full,
    input  logic            pop,
    output sct_pkg::entry_t rd_data,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_STEP = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_STEP = CNT_W'(1);

    sct_pkg::entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_STEP;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_STEP;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_STEP;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_STEP;
            end
        end
    end

endmodule

>>> sv/sct_back.sv
// ----------------------------------------------------------------------------
// Tokenizer back end
// Takes entries from the token queue and delivers their tokens one per
// transfer, marking the last token of each source byte.
// ----------------------------------------------------------------------------
module sct_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  sct_pkg::entry_t rd_data,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [3:0]      kind,
    output logic [19:0]     line_no,
    output logic [15:0]     col_first,
    output logic [15:0]     col_after,
    output logic [23:0]     span_begin,
    output logic [23:0]     span_end,
    output logic [31:0]     num_value,
    output logic            run_last
);

    sct_pkg::entry_t ent_reg;
    sct_pkg::tok_t   cur_tok;
    logic            ent_valid_reg;
    logic            sel_reg;
    logic            out_xfer;
    logic            load;

    assign out_xfer = ent_valid_reg & ~out_stall;
    assign load     = ~ent_valid_reg | (out_xfer & (sel_reg | ~ent_reg.two));
    assign pop      = load & ~empty;

    // Present the selected token
    always_comb
    begin
        cur_tok    = sel_reg ? ent_reg.tok1 : ent_reg.tok0;
        out_valid  = ent_valid_reg;
        kind       = cur_tok.kind;
        line_no    = ent_reg.line_no;
        col_first  = cur_tok.col_first;
        col_after  = cur_tok.col_after;
        span_begin = cur_tok.span_begin;
        span_end   = cur_tok.span_end;
        num_value  = cur_tok.num_value;
        run_last   = sel_reg | ~ent_reg.two;
    end

    // Load entry payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= rd_data;
        end
    end

    // Track entry occupancy and token select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else if (load)
        begin
            ent_valid_reg <= ~empty;
            sel_reg       <= 1'b0;
        end
        else if (out_xfer)
        begin
            sel_reg <= 1'b1;
        end
    end

    // Second token only exists in a pair
    a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (ent_valid_reg && ent_reg.two))
        else $error("second token selected without a pair");

    // First token of a pair is followed by the second
    a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && !sel_reg && ent_reg.two) |=> (out_valid && sel_reg))
        else $error("second token of a pair lost");

    // A new entry always starts at its first token
    a_pop_first: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (!sel_reg && ent_valid_reg))
        else $error("entry loaded without first token selected");

endmodule
